[rtl/core/rerg_pkg.sv]
`default_nettype none
package rerg_pkg;
    localparam int unsigned WordW = 64;
    localparam int unsigned HalfW = 32;
    localparam int unsigned IdxW  = 3;
    localparam int unsigned BlogW = 7;
    localparam int unsigned CfgIdxW = 1;

    // Table depth and backlog ceiling, sized to the result fields
    localparam int unsigned NUM_SEGMENTS = 8;
    localparam int unsigned BACKLOG_CAP  = 64;

    localparam logic [CfgIdxW-1:0] CFG_TPS     = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_LIMITED = 1'd1;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [WordW-1:0] TPS_RESET = 64'd1000000;

    typedef struct packed {
        logic                  req_type;
        logic [WordW-1:0]      tsc_now;
        logic [WordW-1:0]      ms_now;
        logic [IdxW-1:0]       entry_index;
        logic [HalfW-1:0]      entry_duration_ms;
        logic [HalfW-1:0]      entry_rate_start;
        logic [HalfW-1:0]      entry_rate_end;
    } t_req;

    typedef struct packed {
        logic [WordW-1:0] events_due;
        logic [IdxW-1:0]  current_segment;
        logic [BlogW-1:0] backlog_count;
    } t_rsp;

    // Serial arithmetic unit control and status
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
    } t_alu_cmd;

    typedef struct packed {
        logic             done;
        logic [WordW-1:0] result;
    } t_alu_sts;
endpackage
`default_nettype wire

[rtl/core/rerg_if.sv]
`default_nettype none
interface rerg_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/rerg_alu.sv]
`default_nettype none
// Bit-serial unit: 64-bit multiply mod 2^64 (shift-add) or 64/64 divide
// (restoring), one bit per cycle.
module rerg_alu
    import rerg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_alu_cmd i_cmd,
    output t_alu_sts      o_sts
);
    logic [WordW-1:0] r_a, n_a, r_b, n_b, r_acc, n_acc, r_rem, n_rem;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    t_op              r_op, n_op;
    logic [WordW:0]   w_trial;

    always_comb begin
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_rem = r_rem;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0; n_op = r_op;
        w_trial = {r_rem, r_a[WordW-1]} - {1'b0, r_b};
        if (i_cmd.start) begin
            n_a = i_cmd.a; n_b = i_cmd.b; n_acc = '0; n_rem = '0;
            n_cnt = 7'd0; n_busy = 1'b1; n_op = i_cmd.op;
        end else if (r_busy) begin
            // advance one bit
            if (r_op == OP_MUL) begin
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a = {r_a[WordW-2:0], 1'b0};
                n_b = {1'b0, r_b[WordW-1:1]};
            end else begin
                if (!w_trial[WordW]) begin
                    n_rem = w_trial[WordW-1:0];
                    n_acc = {r_acc[WordW-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[WordW-2:0], r_a[WordW-1]};
                    n_acc = {r_acc[WordW-2:0], 1'b0};
                end
                n_a = {r_a[WordW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(WordW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_rem <= n_rem;
        r_cnt <= n_cnt; r_op <= n_op;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.result = r_acc;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 7'(WordW)) else $error("bit count overran");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
endmodule
`default_nettype wire

[rtl/core/ramped_event_rate_generator_unit.sv]
`default_nettype none
// Ramped event rate generator. Each beat on the request channel is a tick
// or a segment write and gives one result beat. A write goes from the rate
// step straight to the done step after it is accepted. A full tick runs
// six operations through a single bit-serial multiply/divide unit that
// retires one bit per cycle (the segment rate offset times slope, divided
// by the duration; the counter delta times rate; the divide by ticks per
// second; ticks per second times count; and that divided by rate), and
// besides these it picks the segment, starts the delta product and loads
// the result. Ticks that end early (first latch, zero rate, too small
// delta) skip the later operations. One item is worked on at a time; a new
// request is taken the cycle after the previous result is loaded, and a
// finished item waits in its last step while the result register is
// still full. The segment table is cleared at reset.
module ramped_event_rate_generator_unit
    import rerg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rerg_if.sink                      i_req,
    rerg_if.source                    o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [WordW-1:0]     i_cfg_data
);
    localparam int unsigned SegW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RATE = 9'b000000010,
        S_RMUL = 9'b000000100,
        S_RDIV = 9'b000001000,
        S_DMUL = 9'b000010000,
        S_NDIV = 9'b000100000,
        S_TMUL = 9'b001000000,
        S_TDIV = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    logic [WordW-1:0] r_tps, r_last, r_rate, r_n;
    logic             r_lim;
    logic [SegW-1:0]  r_ptr;
    logic [BlogW-1:0] r_blog;
    logic [HalfW-1:0] r_dur  [NUM_SEGMENTS];
    logic [HalfW-1:0] r_from [NUM_SEGMENTS];
    logic [HalfW-1:0] r_to   [NUM_SEGMENTS];
    logic [WordW-1:0] r_began[NUM_SEGMENTS];
    logic             r_rdown;
    logic             r_ovalid;
    logic             r_dm_run;
    t_rsp             r_rsp;

    t_alu_cmd w_cmd;
    t_alu_sts w_sts;

    rerg_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts));

    logic [WordW-1:0] w_tps, w_off, w_dur, w_from, w_to, w_delta;
    logic [SegW-1:0]  w_widx;
    logic             w_widx_ok;
    logic             w_seg_end;
    logic             w_load;
    logic [WordW-1:0] w_due;
    logic [BlogW-1:0] w_blog_nx;
    assign w_tps   = (r_tps == '0) ? WordW'(1) : r_tps;
    assign w_dur   = WordW'(r_dur[r_ptr]);
    assign w_from  = WordW'(r_from[r_ptr]);
    assign w_to    = WordW'(r_to[r_ptr]);
    assign w_off   = r_req.ms_now - r_began[r_ptr];
    assign w_delta = r_req.tsc_now - r_last;
    assign w_widx  = SegW'(r_req.entry_index);
    assign w_widx_ok = 32'(r_req.entry_index) < NUM_SEGMENTS;
    assign w_seg_end = (w_dur != '0) && (r_began[r_ptr] != '0) && (w_off >= w_dur);
    assign w_load  = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    // sequence one item
    always_comb begin
        n_state = r_state;
        w_cmd   = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};
        unique case (r_state)
            S_IDLE: if (i_req.valid && i_req.ready) n_state = S_RATE;
            S_RATE: begin
                if (r_req.req_type == REQ_WRITE || r_last == '0) n_state = S_DONE;
                else if (w_dur != '0 && r_began[r_ptr] != '0 && w_off < w_dur
                         && w_from != w_to) begin
                    w_cmd = '{start: 1'b1, op: OP_MUL, a: w_off,
                              b: (w_from > w_to) ? w_from - w_to : w_to - w_from};
                    n_state = S_RMUL;
                end else n_state = S_DMUL;
            end
            S_RMUL: if (w_sts.done) begin
                w_cmd = '{start: 1'b1, op: OP_DIV, a: w_sts.result, b: w_dur};
                n_state = S_RDIV;
            end
            S_RDIV: if (w_sts.done) n_state = S_DMUL;
            S_DMUL: begin
                // start delta * rate on entry unless the rate is zero, then test and divide
                if (!r_dm_run) begin
                    if (r_rate == '0) n_state = S_DONE;
                    else w_cmd = '{start: 1'b1, op: OP_MUL, a: w_delta, b: r_rate};
                end else if (w_sts.done) begin
                    if (w_sts.result < w_tps) n_state = S_DONE;
                    else begin
                        w_cmd = '{start: 1'b1, op: OP_DIV, a: w_sts.result, b: w_tps};
                        n_state = S_NDIV;
                    end
                end
            end
            S_NDIV: if (w_sts.done) begin
                w_cmd = '{start: 1'b1, op: OP_MUL, a: w_tps, b: w_sts.result};
                n_state = S_TMUL;
            end
            S_TMUL: if (w_sts.done) begin
                w_cmd = '{start: 1'b1, op: OP_DIV, a: w_sts.result, b: r_rate};
                n_state = S_TDIV;
            end
            S_TDIV: if (w_sts.done) n_state = S_DONE;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // shape the count for limited mode and track the backlog
    always_comb begin
        w_due     = '0;
        w_blog_nx = r_blog;
        if (r_req.req_type == REQ_TICK) begin
            if (!r_lim) w_due = r_n;
            else if (r_n == '0) begin
                if (r_blog != '0) begin
                    w_blog_nx = r_blog - BlogW'(1);
                    w_due     = WordW'(1);
                end
            end else begin
                w_due = WordW'(1);
                if (r_n - WordW'(1) >= WordW'(BACKLOG_CAP) - WordW'(r_blog))
                    w_blog_nx = BlogW'(BACKLOG_CAP);
                else w_blog_nx = r_blog + BlogW'(r_n - WordW'(1));
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_req <= i_req.data;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tps    <= TPS_RESET;
            r_lim    <= 1'b1;
            r_last   <= '0;
            r_ptr    <= '0;
            r_blog   <= '0;
            r_ovalid <= 1'b0;
            r_dm_run <= 1'b0;
            for (int i = 0; i < NUM_SEGMENTS; i++) begin
                r_dur[i] <= '0; r_from[i] <= '0; r_to[i] <= '0; r_began[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TPS) r_tps <= i_cfg_data;
                else if (i_cfg_idx == CFG_LIMITED) r_lim <= i_cfg_data[0];
            end
            if (w_load) r_ovalid <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            r_dm_run <= (r_state == S_DMUL) && (n_state == S_DMUL);
            if (r_state == S_IDLE) r_n <= '0;
            unique case (r_state)
                S_RATE: begin
                    r_rdown <= w_from > w_to;
                    r_rate  <= w_seg_end ? w_to : w_from;
                    if (r_req.req_type == REQ_WRITE) begin
                        if (w_widx_ok) begin
                            r_dur[w_widx]   <= r_req.entry_duration_ms;
                            r_from[w_widx]  <= r_req.entry_rate_start;
                            r_to[w_widx]    <= r_req.entry_rate_end;
                            r_began[w_widx] <= '0;
                        end
                    end else if (r_last == '0) begin
                        r_last <= r_req.tsc_now;
                    end else if (w_dur != '0) begin
                        if (r_began[r_ptr] == '0) r_began[r_ptr] <= r_req.ms_now;
                        else if (w_seg_end) begin
                            if (32'(r_ptr) + 1 < NUM_SEGMENTS) r_ptr <= r_ptr + SegW'(1);
                        end
                    end
                end
                S_RDIV: if (w_sts.done)
                    r_rate <= r_rdown ? r_rate - w_sts.result : r_rate + w_sts.result;
                S_NDIV: if (w_sts.done) r_n <= w_sts.result;
                S_TDIV: if (w_sts.done) r_last <= r_last + w_sts.result;
                S_DONE: if (w_load) begin
                    r_blog <= w_blog_nx;
                    r_rsp  <= '{events_due: w_due, current_segment: IdxW'(r_ptr),
                               backlog_count: w_blog_nx};
                end
                default: ;
            endcase
        end
    end

    a_backlog_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blog <= BlogW'(BACKLOG_CAP)) else $error("backlog above cap");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < NUM_SEGMENTS) else $error("segment pointer out of range");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_state == S_RATE) else $error("accept lost");
    a_lim_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_lim) |-> r_rsp.events_due <= WordW'(1))
        else $error("limited mode released more than one");
endmodule
`default_nettype wire
